// ===== rtl/sid_pkg.sv =====
// Shared types and constants for the silence interval detector.
// Holds the phase codes, state and result structs, and register indexes.
// No dependencies.
package sid_pkg;

    // Widths of the internal counters
    localparam int INDEX_BITS = 32;
    localparam int HOLD_BITS  = 20;

    // Widths fixed by the item and register fields
    localparam int SAMPLE_BITS = 16;
    localparam int LEVEL_BITS  = 16;
    localparam int CFG_HOLD_BITS = 20;
    localparam int CFG_DATA_BITS = 20;
    localparam int CFG_IDX_BITS  = 2;
    localparam int OUT_BITS      = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SILENCE_LEVEL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PRE_HOLD      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_POST_HOLD     = 2'd2;

    // Register reset values
    localparam logic [LEVEL_BITS-1:0]    LEVEL_RESET     = 16'd1;
    localparam logic [CFG_HOLD_BITS-1:0] PRE_HOLD_RESET  = 20'd882;
    localparam logic [CFG_HOLD_BITS-1:0] POST_HOLD_RESET = 20'd4410;

    // Detector phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PRE   = 2'd1,
        PH_FOUND = 2'd2,
        PH_POST  = 2'd3
    } sid_phase_t;

    typedef struct packed {
        sid_phase_t              phase;
        logic [HOLD_BITS-1:0]    hold_count;
        logic [INDEX_BITS-1:0]   sample_index;
        logic [INDEX_BITS-1:0]   silence_start;
    } sid_state_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] start_index;
        logic [OUT_BITS-1:0] length_samples;
        logic                at_end;
    } sid_result_t;

endpackage

// ===== rtl/sid_step.sv =====
// Per-sample update of the silence detector: quiet test, phase and counters.
// Purely combinational; depends on sid_pkg for the state and result types.
module sid_step (
    input  sid_pkg::sid_state_t                       state_i,
    input  logic signed [sid_pkg::SAMPLE_BITS-1:0]    sample_i,
    input  logic                                      last_i,
    input  logic [sid_pkg::LEVEL_BITS-1:0]            level_i,
    input  logic [sid_pkg::CFG_HOLD_BITS-1:0]         pre_hold_i,
    input  logic [sid_pkg::CFG_HOLD_BITS-1:0]         post_hold_i,
    output sid_pkg::sid_state_t                       state_o,
    output logic                                      res_valid_o,
    output sid_pkg::sid_result_t                      res_o
);

    localparam int MAG_BITS = sid_pkg::SAMPLE_BITS + 1;
    localparam int CMP_BITS = (sid_pkg::CFG_HOLD_BITS > sid_pkg::HOLD_BITS)
                              ? sid_pkg::CFG_HOLD_BITS : sid_pkg::HOLD_BITS;
    localparam int PAD_BITS = (sid_pkg::INDEX_BITS > sid_pkg::OUT_BITS)
                              ? sid_pkg::INDEX_BITS : sid_pkg::OUT_BITS;
    localparam logic [CMP_BITS-1:0] HOLD_MAX_EXT =
        CMP_BITS'({sid_pkg::HOLD_BITS{1'b1}});
    localparam logic [sid_pkg::INDEX_BITS-1:0] INDEX_MAX = '1;

    logic [MAG_BITS-1:0]           mag;
    logic                          quiet;
    logic [CMP_BITS-1:0]           pre_ext;
    logic [CMP_BITS-1:0]           post_ext;
    logic [sid_pkg::HOLD_BITS-1:0] pre_sat;
    logic [sid_pkg::HOLD_BITS-1:0] post_sat;
    logic [sid_pkg::HOLD_BITS-1:0] hold_dec;
    logic [sid_pkg::INDEX_BITS-1:0] length_raw;
    logic [PAD_BITS-1:0]           start_pad;
    logic [PAD_BITS-1:0]           length_pad;
    sid_pkg::sid_state_t           mid;
    logic                          emit_normal;

    // Magnitude of the sample, 0..32768
    always_comb begin
        if (sample_i[sid_pkg::SAMPLE_BITS-1]) begin
            mag = MAG_BITS'(~sample_i) + MAG_BITS'(1);
        end else begin
            mag = MAG_BITS'(sample_i);
        end
    end
    assign quiet = mag < MAG_BITS'(level_i);

    // Saturate the hold registers into the counter range
    assign pre_ext  = CMP_BITS'(pre_hold_i);
    assign post_ext = CMP_BITS'(post_hold_i);
    assign pre_sat  = (pre_ext > HOLD_MAX_EXT) ? '1 : sid_pkg::HOLD_BITS'(pre_ext);
    assign post_sat = (post_ext > HOLD_MAX_EXT) ? '1 : sid_pkg::HOLD_BITS'(post_ext);

    // Count down without going below zero
    assign hold_dec = (state_i.hold_count != '0)
                      ? state_i.hold_count - sid_pkg::HOLD_BITS'(1) : '0;

    // Advance the phase for this sample
    always_comb begin
        mid         = state_i;
        emit_normal = 1'b0;
        if (quiet) begin
            case (state_i.phase)
                sid_pkg::PH_IDLE: begin
                    mid.phase      = sid_pkg::PH_PRE;
                    mid.hold_count = pre_sat;
                end
                sid_pkg::PH_PRE: begin
                    mid.hold_count = hold_dec;
                    if (hold_dec == '0) begin
                        mid.phase         = sid_pkg::PH_FOUND;
                        mid.silence_start = state_i.sample_index;
                    end
                end
                sid_pkg::PH_POST: begin
                    mid.phase      = sid_pkg::PH_FOUND;
                    mid.hold_count = '0;
                end
                default: begin
                end
            endcase
        end else begin
            case (state_i.phase)
                sid_pkg::PH_FOUND: begin
                    mid.phase      = sid_pkg::PH_POST;
                    mid.hold_count = post_sat;
                end
                sid_pkg::PH_POST: begin
                    mid.hold_count = hold_dec;
                    if (hold_dec == '0) begin
                        emit_normal = 1'b1;
                        mid.phase   = sid_pkg::PH_IDLE;
                    end
                end
                sid_pkg::PH_PRE: begin
                    mid.phase      = sid_pkg::PH_IDLE;
                    mid.hold_count = '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Result fields come from the start and index before the index moves
    assign length_raw = state_i.sample_index - mid.silence_start;
    assign start_pad  = PAD_BITS'(mid.silence_start);
    assign length_pad = PAD_BITS'(length_raw);

    // Flush on the last sample, else advance the saturating index
    always_comb begin
        state_o     = mid;
        res_valid_o = emit_normal;
        res_o.start_index    = start_pad[sid_pkg::OUT_BITS-1:0];
        res_o.length_samples = length_pad[sid_pkg::OUT_BITS-1:0];
        res_o.at_end         = 1'b0;
        if (last_i) begin
            if (mid.phase == sid_pkg::PH_FOUND || mid.phase == sid_pkg::PH_POST) begin
                res_valid_o  = 1'b1;
                res_o.at_end = 1'b1;
            end
            state_o.phase         = sid_pkg::PH_IDLE;
            state_o.hold_count    = '0;
            state_o.sample_index  = '0;
            state_o.silence_start = '0;
        end else if (state_i.sample_index != INDEX_MAX) begin
            state_o.sample_index = state_i.sample_index + sid_pkg::INDEX_BITS'(1);
        end
    end

endmodule

// ===== rtl/sid_outq.sv =====
// Two-entry result queue between the detector and the result channel.
// Lets a new sample be taken while one result waits; depends on sid_pkg.
module sid_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_i,
    input  sid_pkg::sid_result_t  push_data_i,
    output logic                  full_o,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sid_pkg::sid_result_t  m_data
);

    sid_pkg::sid_result_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = count_reg != 2'd0;
    assign full_o  = count_reg == 2'd2;
    assign m_data  = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push_i && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (!push_i && pop) begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers and the fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push_i) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Store the incoming result
    always_ff @(posedge aclk) begin
        if (push_i) begin
            entry_reg[wr_ptr_reg] <= push_data_i;
        end
    end

endmodule

// ===== rtl/silence_interval_detector_core.sv =====
// Top level of the silence interval detector: registers, state, result queue.
// Depends on sid_pkg, sid_step and sid_outq.
//
// Usage: samples arrive on the s_ request channel (s_sample, s_last) with
// valid/ready. Each accepted sample updates the detector state register,
// so a sample can be taken every cycle while the queue has room. A sample
// that ends a silence, or a last sample that flushes an open silence,
// produces one request on the m_ channel (start index, length in samples,
// at_end flag), written into the result queue as the sample is accepted.
// Results pass through a two-entry queue: while one result waits for
// m_ready the block keeps taking samples; s_ready drops only when both
// entries are held. The queue depth sets the only stall path.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect on the
// next clock edge and are meant for idle periods; index 3 is ignored.
// Reset (aresetn low, synchronous) returns the detector to idle with the
// sample index at zero, empties the queue and loads the register defaults.
// A sample with s_last set resets the index and phase after it is handled.
module silence_interval_detector_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [sid_pkg::SAMPLE_BITS-1:0] s_sample,
    input  logic                                   s_last,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [sid_pkg::OUT_BITS-1:0]           m_start_index,
    output logic [sid_pkg::OUT_BITS-1:0]           m_length_samples,
    output logic                                   m_at_end,
    input  logic                                   cfg_we,
    input  logic [sid_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [sid_pkg::CFG_DATA_BITS-1:0]      cfg_wdata
);

    logic [sid_pkg::LEVEL_BITS-1:0]    level_reg;
    logic [sid_pkg::CFG_HOLD_BITS-1:0] pre_hold_reg;
    logic [sid_pkg::CFG_HOLD_BITS-1:0] post_hold_reg;
    sid_pkg::sid_state_t               state_reg;
    sid_pkg::sid_state_t               state_next;
    logic                              res_valid;
    sid_pkg::sid_result_t              res;
    sid_pkg::sid_result_t              out_data;
    logic                              q_full;
    logic                              accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg     <= sid_pkg::LEVEL_RESET;
            pre_hold_reg  <= sid_pkg::PRE_HOLD_RESET;
            post_hold_reg <= sid_pkg::POST_HOLD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                sid_pkg::REG_SILENCE_LEVEL: level_reg <= cfg_wdata[sid_pkg::LEVEL_BITS-1:0];
                sid_pkg::REG_PRE_HOLD:      pre_hold_reg  <= cfg_wdata;
                sid_pkg::REG_POST_HOLD:     post_hold_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    sid_step u_step (
        .state_i     (state_reg),
        .sample_i    (s_sample),
        .last_i      (s_last),
        .level_i     (level_reg),
        .pre_hold_i  (pre_hold_reg),
        .post_hold_i (post_hold_reg),
        .state_o     (state_next),
        .res_valid_o (res_valid),
        .res_o       (res)
    );

    // Hold detector state, advance on each accepted sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= sid_pkg::PH_IDLE;
            state_reg.hold_count    <= '0;
            state_reg.sample_index  <= '0;
            state_reg.silence_start <= '0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    sid_outq u_outq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push_i      (accept && res_valid),
        .push_data_i (res),
        .full_o      (q_full),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (out_data)
    );

    assign m_start_index    = out_data.start_index;
    assign m_length_samples = out_data.length_samples;
    assign m_at_end         = out_data.at_end;

    // A full queue always has a result on offer
    assert property (@(posedge aclk) disable iff (!aresetn) !s_ready |-> m_valid)
        else $error("queue full without a pending result");

    // A last sample returns the detector to idle at index zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last) |=>
            (state_reg.phase == sid_pkg::PH_IDLE && state_reg.sample_index == '0))
        else $error("last sample did not reset the detector");

    // Idle and confirmed-silence phases carry no pending hold count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == sid_pkg::PH_IDLE || state_reg.phase == sid_pkg::PH_FOUND)
            |-> state_reg.hold_count == '0)
        else $error("hold count left over outside a hold phase");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for silence_interval_detector_core.
// Holds a detector predictor, a request driver, a result monitor and a watchdog.
// Depends on sid_pkg and the detector RTL only.
module tb_top;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned RANDOM_PHASES  = 12;
    localparam int unsigned PHASE_ITEMS    = 130;
    localparam logic [sid_pkg::CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [sid_pkg::SAMPLE_BITS-1:0] smp;
        logic                            lst;
    } audio_item_t;

    // Clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #5 aclk = ~aclk;
    end

    // Block ports
    logic                                   s_valid  = 1'b0;
    logic                                   s_ready;
    logic signed [sid_pkg::SAMPLE_BITS-1:0] s_sample = '0;
    logic                                   s_last   = 1'b0;
    logic                                   m_valid;
    logic                                   m_ready  = 1'b0;
    logic [sid_pkg::OUT_BITS-1:0]           m_start_index;
    logic [sid_pkg::OUT_BITS-1:0]           m_length_samples;
    logic                                   m_at_end;
    logic                                   cfg_we    = 1'b0;
    logic [sid_pkg::CFG_IDX_BITS-1:0]       cfg_index = '0;
    logic [sid_pkg::CFG_DATA_BITS-1:0]      cfg_wdata = '0;

    silence_interval_detector_core uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_last           (s_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_start_index    (m_start_index),
        .m_length_samples (m_length_samples),
        .m_at_end         (m_at_end),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    // Pending samples, expected silences and bookkeeping
    audio_item_t           sample_q[$];
    sid_pkg::sid_result_t  silence_q[$];
    int unsigned           item_total   = 0;
    int unsigned           mismatches   = 0;
    int unsigned           stuck_cycles = 0;
    int unsigned           gap_left     = 0;
    int unsigned           ready_left   = 0;
    bit                    calm         = 1'b0;
    logic                  ready_on;
    audio_item_t           next_item;
    sid_pkg::sid_result_t  want;

    // Predictor copy of registers and detector state
    logic [sid_pkg::LEVEL_BITS-1:0]    reg_level;
    logic [sid_pkg::CFG_HOLD_BITS-1:0] reg_pre;
    logic [sid_pkg::CFG_HOLD_BITS-1:0] reg_post;
    sid_pkg::sid_phase_t               det_phase;
    logic [sid_pkg::HOLD_BITS-1:0]     det_hold;
    logic [sid_pkg::INDEX_BITS-1:0]    det_index;
    logic [sid_pkg::INDEX_BITS-1:0]    det_start;

    // Advance the detector by one sample and queue any silence it closes
    function automatic void advance_detector(input logic [sid_pkg::SAMPLE_BITS-1:0] smp,
                                             input logic lst);
        logic [sid_pkg::SAMPLE_BITS:0] mag;
        logic                          quiet;
        logic                          closed;
        sid_pkg::sid_result_t          res;
        mag = smp[sid_pkg::SAMPLE_BITS-1] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        quiet = (mag < {1'b0, reg_level});
        closed = 1'b0;
        res = '0;
        if (quiet) begin
            case (det_phase)
                sid_pkg::PH_IDLE: begin
                    det_phase = sid_pkg::PH_PRE;
                    det_hold  = reg_pre;
                end
                sid_pkg::PH_PRE: begin
                    if (det_hold != '0) det_hold = det_hold - 1'b1;
                    if (det_hold == '0) begin
                        det_phase = sid_pkg::PH_FOUND;
                        det_start = det_index;
                    end
                end
                sid_pkg::PH_POST: begin
                    det_phase = sid_pkg::PH_FOUND;
                    det_hold  = '0;
                end
                default: ;
            endcase
        end else begin
            case (det_phase)
                sid_pkg::PH_FOUND: begin
                    det_phase = sid_pkg::PH_POST;
                    det_hold  = reg_post;
                end
                sid_pkg::PH_POST: begin
                    if (det_hold != '0) det_hold = det_hold - 1'b1;
                    if (det_hold == '0) begin
                        res.start_index    = det_start;
                        res.length_samples = det_index - det_start;
                        res.at_end         = 1'b0;
                        closed             = 1'b1;
                        det_phase          = sid_pkg::PH_IDLE;
                    end
                end
                sid_pkg::PH_PRE: begin
                    det_phase = sid_pkg::PH_IDLE;
                    det_hold  = '0;
                end
                default: ;
            endcase
        end
        // flush an open silence at end of stream, then restart the index
        if (lst) begin
            if (det_phase == sid_pkg::PH_FOUND || det_phase == sid_pkg::PH_POST) begin
                res.start_index    = det_start;
                res.length_samples = det_index - det_start;
                res.at_end         = 1'b1;
                closed             = 1'b1;
            end
            det_phase = sid_pkg::PH_IDLE;
            det_hold  = '0;
            det_index = '0;
            det_start = '0;
        end else if (det_index != '1) begin
            det_index = det_index + 1'b1;
        end
        if (closed) silence_q.push_back(res);
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [sid_pkg::SAMPLE_BITS-1:0] with_sign(input int unsigned m);
        if (m >= 32768) return 16'h8000;
        if ($urandom_range(0, 1) != 0) return 16'(0 - m);
        return 16'(m);
    endfunction

    // Sample with magnitude below the level (level at least 1)
    function automatic logic [sid_pkg::SAMPLE_BITS-1:0] quiet_sample(input int unsigned lvl);
        return with_sign($urandom_range(0, (lvl - 1 > 32768) ? 32768 : lvl - 1));
    endfunction

    // Sample with magnitude at or above the level (level at most 32768)
    function automatic logic [sid_pkg::SAMPLE_BITS-1:0] loud_sample(input int unsigned lvl);
        return with_sign($urandom_range(lvl, 32768));
    endfunction

    function automatic void push_item(input logic [sid_pkg::SAMPLE_BITS-1:0] smp,
                                      input logic lst);
        sample_q.push_back('{smp, lst});
        item_total++;
    endfunction

    function automatic void note_mismatch(input string what, input logic [31:0] exp_v,
                                          input logic [31:0] got_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, exp_v, got_v);
    endfunction

    task automatic write_reg(input logic [sid_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [sid_pkg::CFG_DATA_BITS-1:0] data);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
    endtask

    task automatic end_writes();
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [sid_pkg::CFG_DATA_BITS-1:0] lvl,
                            input logic [sid_pkg::CFG_DATA_BITS-1:0] pre,
                            input logic [sid_pkg::CFG_DATA_BITS-1:0] post);
        write_reg(sid_pkg::REG_SILENCE_LEVEL, lvl);
        write_reg(sid_pkg::REG_PRE_HOLD, pre);
        write_reg(sid_pkg::REG_POST_HOLD, post);
        end_writes();
    endtask

    // Wait until every request is taken and every silence has come back
    task automatic wait_idle();
        do @(negedge aclk);
        while (sample_q.size() != 0 || s_valid || silence_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One random register setting followed by mostly well-formed silences
    task automatic random_phase(input int unsigned n_items);
        int unsigned lvl, pre, post, r, q_len, l_len, k, first;
        r = $urandom_range(0, 9);
        if (r <= 5)      lvl = $urandom_range(1, 1024);
        else if (r <= 7) lvl = $urandom_range(1, 32768);
        else if (r == 8) lvl = 32768;
        else             lvl = 1;
        pre  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(0, 12);
        post = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(0, 12);
        calm = ($urandom_range(0, 3) == 0);
        set_regs(20'(lvl), 20'(pre), 20'(post));
        if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_UNUSED, 20'($urandom));
            end_writes();
        end
        first = item_total;
        while (item_total - first < n_items) begin
            r = $urandom_range(0, 9);
            if (r <= 6) begin
                // quiet run, sometimes cut short of confirmation
                q_len = pre + $urandom_range(1, 6);
                if ($urandom_range(0, 5) == 0) q_len = $urandom_range(1, pre + 1);
                for (k = 0; k < q_len; k++) push_item(quiet_sample(lvl), 1'b0);
                // loud run, sometimes cut short of the end
                l_len = post + $urandom_range(1, 4);
                if ($urandom_range(0, 4) == 0) l_len = $urandom_range(1, post + 1);
                for (k = 0; k < l_len; k++) push_item(loud_sample(lvl), 1'b0);
            end else if (r <= 8) begin
                l_len = $urandom_range(1, 6);
                for (k = 0; k < l_len; k++) push_item(16'($urandom), 1'b0);
            end else begin
                push_item(16'($urandom), 1'b1);
            end
        end
        if ($urandom_range(0, 1) != 0) push_item(16'($urandom), 1'b1);
        wait_idle();
    endtask

    // Drive requests and track registers and detector state
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_sample  <= '0;
            s_last    <= 1'b0;
            gap_left  = 0;
            reg_level = sid_pkg::LEVEL_RESET;
            reg_pre   = sid_pkg::PRE_HOLD_RESET;
            reg_post  = sid_pkg::POST_HOLD_RESET;
            det_phase = sid_pkg::PH_IDLE;
            det_hold  = '0;
            det_index = '0;
            det_start = '0;
        end else begin
            // follow register writes
            if (cfg_we) begin
                case (cfg_index)
                    sid_pkg::REG_SILENCE_LEVEL:
                        reg_level = cfg_wdata[sid_pkg::LEVEL_BITS-1:0];
                    sid_pkg::REG_PRE_HOLD:      reg_pre   = cfg_wdata;
                    sid_pkg::REG_POST_HOLD:     reg_post  = cfg_wdata;
                    default: ;
                endcase
            end
            // predict each accepted request
            if (s_valid && s_ready) advance_detector(s_sample, s_last);
            // offer the next request once the slot is free
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    next_item = sample_q.pop_front();
                    s_sample  <= next_item.smp;
                    s_last    <= next_item.lst;
                    s_valid   <= 1'b1;
                    gap_left  = calm ? 0 : pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the result channel in random stretches
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_left = 0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left--;
        end else begin
            ready_on   = ($urandom_range(0, 2) != 0);
            m_ready    <= ready_on;
            ready_left = ready_on ? $urandom_range(0, 8) : pick_gap();
        end
    end

    // Compare each accepted result with the oldest expected silence
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (silence_q.size() == 0) begin
                note_mismatch("start_index of unexpected result", '0, m_start_index);
            end else begin
                want = silence_q.pop_front();
                if (m_start_index !== want.start_index)
                    note_mismatch("start_index", want.start_index, m_start_index);
                if (m_length_samples !== want.length_samples)
                    note_mismatch("length_samples", want.length_samples, m_length_samples);
                if (m_at_end !== want.at_end)
                    note_mismatch("at_end", 32'(want.at_end), 32'(m_at_end));
            end
        end
    end

    // Drop the run when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial begin
        int unsigned k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: short holds, extremes, interrupted runs and end flushes
        set_regs(20'd100, 20'd0, 20'd1);
        push_item(16'sd32767, 1'b0);
        push_item(16'h8000, 1'b0);
        push_item(16'sd0, 1'b0);
        push_item(16'sd99, 1'b0);
        push_item(-16'sd99, 1'b0);
        push_item(16'sd100, 1'b0);
        push_item(-16'sd100, 1'b0);
        push_item(-16'sd1, 1'b0);
        push_item(16'sd5, 1'b0);
        push_item(16'sd32767, 1'b0);
        push_item(16'sd1, 1'b0);
        push_item(16'h8000, 1'b0);
        push_item(16'sd200, 1'b0);
        push_item(16'sd0, 1'b0);
        push_item(16'sd300, 1'b0);
        push_item(16'sd0, 1'b0);
        push_item(16'sd0, 1'b0);
        push_item(16'sd50, 1'b1);
        push_item(16'sd0, 1'b0);
        push_item(16'sd0, 1'b0);
        push_item(16'sd1000, 1'b0);
        push_item(-16'sd1000, 1'b1);
        push_item(16'h8000, 1'b1);
        wait_idle();

        // Level zero: nothing is quiet, widest pre hold, zero post hold
        set_regs(20'd0, 20'hFFFFF, 20'd0);
        push_item(16'sd0, 1'b0);
        push_item(16'sd0, 1'b0);
        push_item(16'h8000, 1'b0);
        push_item(16'sd32767, 1'b0);
        push_item(16'sd1, 1'b1);
        wait_idle();

        // Oversized level write: every sample is quiet, flush at end
        set_regs(20'hFFFFF, 20'd2, 20'hFFFFF);
        for (k = 0; k < 12; k++) push_item(16'($urandom), 1'b0);
        push_item(16'h8000, 1'b0);
        push_item(16'h7FFF, 1'b0);
        push_item(16'h8000, 1'b1);
        wait_idle();

        // Top level value: only the most negative sample is loud
        set_regs(20'd32768, 20'd0, 20'hFFFFF);
        write_reg(REG_UNUSED, 20'd0);
        end_writes();
        push_item(16'sd0, 1'b0);
        push_item(16'sd0, 1'b0);
        for (k = 0; k < 30; k++) push_item(16'h8000, 1'b0);
        push_item(16'h7FFF, 1'b0);
        push_item(16'h8000, 1'b1);
        wait_idle();

        // Widest pre hold never confirms
        set_regs(20'd32768, 20'hFFFFF, 20'd0);
        write_reg(REG_UNUSED, 20'hFFFFF);
        end_writes();
        for (k = 0; k < 40; k++) push_item(quiet_sample(32768), 1'b0);
        push_item(16'h8000, 1'b0);
        push_item(16'sd0, 1'b1);
        wait_idle();

        // Random settings and streams
        for (k = 0; k < RANDOM_PHASES; k++) random_phase(PHASE_ITEMS);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sid_pkg.sv
rtl/sid_step.sv
rtl/sid_outq.sv
rtl/silence_interval_detector_core.sv
tb/tb_top.sv
